>>> hw/rtl/unpremultiply_argb_pixel_defines.svh
`ifndef UNPREMULTIPLY_ARGB_PIXEL_DEFINES_SVH
`define UNPREMULTIPLY_ARGB_PIXEL_DEFINES_SVH

// same-cycle check, off while reset is held
`define UPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upm check failed");

// next-cycle check, off while reset is held
`define UPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upm check failed");

`endif

>>> hw/rtl/upm_pkg.sv
package upm_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_W     = 16;
  localparam int unsigned RCP_SHIFT = 16;
  localparam int unsigned RCP_W     = RCP_SHIFT + 1;
  localparam int unsigned PROD_W    = NUM_W + CH_W;
  localparam int unsigned NUM_CH    = 3;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [RCP_W-1:0] rcp_t;

  // side info that travels beside the channel dividers
  typedef struct packed {
    logic  valid;
    logic  zero;
    chan_t alpha;
  } side_t;

endpackage

>>> hw/rtl/upm_chan.sv
module upm_chan (
  input  logic          clk,
  input  upm_pkg::num_t num_i,
  input  upm_pkg::chan_t den_i,
  input  upm_pkg::rcp_t rcp_i,
  output upm_pkg::chan_t quo_o,
  output logic          clip_o
);
  import upm_pkg::*;

  // stage 2: reciprocal multiply gives an estimate low by at most one
  num_t                    num2_r, num2_nxt;
  chan_t                   den2_r;
  num_t                    est2_r, est2_nxt;
  logic [NUM_W+RCP_W-1:0]  prod1;

  // stage 3: back-multiply the estimate
  num_t                    num3_r;
  chan_t                   den3_r;
  num_t                    est3_r;
  logic [PROD_W-1:0]       back3_r, back3_nxt;

  // stage 4: correct by one and saturate
  chan_t                   quo_r, quo_nxt;
  logic                    clip_r, clip_nxt;
  num_t                    rem;
  logic                    bump;
  logic [NUM_W:0]          quo_full;

  assign num2_nxt = num_i;
  assign prod1    = (NUM_W+RCP_W)'(num_i) * (NUM_W+RCP_W)'(rcp_i);
  assign est2_nxt = prod1[RCP_SHIFT +: NUM_W];

  always_ff @(posedge clk) begin
    num2_r <= num2_nxt;
    den2_r <= den_i;
    est2_r <= est2_nxt;
  end

  assign back3_nxt = PROD_W'(est2_r) * PROD_W'(den2_r);

  always_ff @(posedge clk) begin
    num3_r  <= num2_r;
    den3_r  <= den2_r;
    est3_r  <= est2_r;
    back3_r <= back3_nxt;
  end

  // estimate never overshoots, so the remainder is non-negative
  assign rem      = num3_r - back3_r[NUM_W-1:0];
  assign bump     = (rem >= {{(NUM_W-CH_W){1'b0}}, den3_r});
  assign quo_full = {1'b0, est3_r} + {{NUM_W{1'b0}}, bump};

  always_comb begin
    if (quo_full > {{(NUM_W+1-CH_W){1'b0}}, CH_MAX}) begin
      quo_nxt  = CH_MAX;
      clip_nxt = 1'b1;
    end else begin
      quo_nxt  = quo_full[CH_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    clip_r <= clip_nxt;
  end

  assign quo_o  = quo_r;
  assign clip_o = clip_r;

endmodule

>>> hw/rtl/unpremultiply_argb_pixel.sv
// Straight-alpha recovery for one premultiplied ARGB32 pixel.
//
// Input: a pixel transfer happens at a rising edge with start high and busy
// low. busy is always low, so a new pixel may be offered every cycle.
// Output: out_valid is high for exactly one cycle per pixel, with out_red,
// out_green, out_blue, out_alpha and out_clipped; the receiver must take it.
// Each colour becomes (c*255 + alpha/2) / alpha, saturated to 255 with
// out_clipped set when the colour exceeds alpha; zero alpha gives all zeros.
// Configuration: cfg_wdata is written to alpha_present on a cfg_we edge;
// clear means every pixel is treated as alpha 255. Write it only when idle.
// Throughput: one pixel per cycle. Stages are operand prep plus reciprocal
// table lookup, reciprocal multiply, back-multiply, then remainder
// correction and saturation.
// Reset: synchronous active-low rst_n clears all valid bits and sets
// alpha_present; no clearing pass, ready right after reset.
`include "unpremultiply_argb_pixel_defines.svh"

module unpremultiply_argb_pixel (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  upm_pkg::chan_t  in_alpha,
  input  upm_pkg::chan_t  in_red,
  input  upm_pkg::chan_t  in_green,
  input  upm_pkg::chan_t  in_blue,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  output logic            out_valid,
  output upm_pkg::chan_t  out_red,
  output upm_pkg::chan_t  out_green,
  output upm_pkg::chan_t  out_blue,
  output upm_pkg::chan_t  out_alpha,
  output logic            out_clipped
);
  import upm_pkg::*;

  logic  alpha_present_r, alpha_present_nxt;
  logic  accept;
  chan_t a_eff;
  chan_t col [NUM_CH];
  rcp_t  rcp_tbl [2**CH_W];

  side_t side1_r, side1_nxt;
  side_t side2_r, side3_r, side4_r;
  num_t  num1_r [NUM_CH];
  num_t  num1_nxt [NUM_CH];
  rcp_t  rcp1_r, rcp1_nxt;
  chan_t quo [NUM_CH];
  logic  clip [NUM_CH];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign alpha_present_nxt = cfg_we ? cfg_wdata : alpha_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_present_r <= 1'b1;
    end else begin
      alpha_present_r <= alpha_present_nxt;
    end
  end

  // floor(2^16 / a); the zero entry is never used for a result
  for (genvar i = 0; i < 2**CH_W; i++) begin : g_rcp
    localparam int unsigned Den = (i == 0) ? 1 : i;
    localparam rcp_t RcpVal = RCP_W'((1 << RCP_SHIFT) / Den);
    assign rcp_tbl[i] = RcpVal;
  end

  assign a_eff  = alpha_present_r ? in_alpha : CH_MAX;
  assign col[0] = in_red;
  assign col[1] = in_green;
  assign col[2] = in_blue;

  // numerator c*255 + floor(a/2)
  for (genvar c = 0; c < NUM_CH; c++) begin : g_num
    assign num1_nxt[c] = ({col[c], {CH_W{1'b0}}} - {{CH_W{1'b0}}, col[c]})
                       + {{(NUM_W-CH_W+1){1'b0}}, a_eff[CH_W-1:1]};
  end

  assign rcp1_nxt  = rcp_tbl[a_eff];
  assign side1_nxt = '{valid: accept, zero: (a_eff == '0), alpha: a_eff};

  always_ff @(posedge clk) begin
    num1_r <= num1_nxt;
    rcp1_r <= rcp1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
      side4_r.valid <= 1'b0;
    end else begin
      side1_r.valid <= side1_nxt.valid;
      side2_r.valid <= side1_r.valid;
      side3_r.valid <= side2_r.valid;
      side4_r.valid <= side3_r.valid;
    end
    side1_r.zero  <= side1_nxt.zero;
    side1_r.alpha <= side1_nxt.alpha;
    side2_r.zero  <= side1_r.zero;
    side2_r.alpha <= side1_r.alpha;
    side3_r.zero  <= side2_r.zero;
    side3_r.alpha <= side2_r.alpha;
    side4_r.zero  <= side3_r.zero;
    side4_r.alpha <= side3_r.alpha;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    upm_chan u_chan (
      .clk    (clk),
      .num_i  (num1_r[c]),
      .den_i  (side1_r.alpha),
      .rcp_i  (rcp1_r),
      .quo_o  (quo[c]),
      .clip_o (clip[c])
    );
  end

  assign out_valid   = side4_r.valid;
  assign out_alpha   = side4_r.alpha;
  assign out_red     = side4_r.zero ? '0 : quo[0];
  assign out_green   = side4_r.zero ? '0 : quo[1];
  assign out_blue    = side4_r.zero ? '0 : quo[2];
  assign out_clipped = ~side4_r.zero & (clip[0] | clip[1] | clip[2]);

  `UPM_ASSERT_NOW(a_out_from_accept, out_valid, $past(accept, 4))
  `UPM_ASSERT_NOW(a_clip_saturates, out_clipped,
    out_red == CH_MAX || out_green == CH_MAX || out_blue == CH_MAX)
  `UPM_ASSERT_NOW(a_zero_alpha_blank, out_valid && out_alpha == '0,
    out_red == '0 && out_green == '0 && out_blue == '0 && !out_clipped)
  `UPM_ASSERT_NEXT(a_opaque_passthru, accept && !alpha_present_r,
    side1_r.alpha == CH_MAX && !side1_r.zero)

endmodule
